/* src/clnw_pkg.sv */
// ----------------------------------------------------------------------------
// clnw_pkg - shared types, codes and tables for the character LCD nibble writer
// Holds the request codes, the controller/datapath command and status bundles,
// the init sequence table and the Cyrillic recode ROM.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 4;
    localparam int ROW_W    = 2;
    localparam int NIB_W    = 4;
    localparam int WAIT_W   = 13;
    localparam int STEP_W   = 4;

    // Last step index of the init sequence and of a single byte transfer
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

    // Wait times after E falls, in microseconds
    localparam logic [WAIT_W-1:0] WAIT_BASE  = 13'd40;
    localparam logic [WAIT_W-1:0] WAIT_SHORT = 13'd200;
    localparam logic [WAIT_W-1:0] WAIT_CLEAR = 13'd2040;
    localparam logic [WAIT_W-1:0] WAIT_POWER = 13'd5040;

    // Set DDRAM address command flag
    localparam logic [BYTE_W-1:0] CMD_SET_DDRAM = 8'h80;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_CHAR   = 2'd2,
        OP_CURSOR = 2'd3
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              emit;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic init;
    } t_dp_status;

    // Cyrillic recode ROM, indexed by code - 192
    localparam logic [BYTE_W-1:0] CYR_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    // DDRAM base address of each row
    function automatic logic [6:0] row_base(input logic [ROW_W-1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h10;
            2'd3:    base = 7'h50;
            default: base = 7'h00;
        endcase
        return base;
    endfunction

    // Init sequence: wake-up nibbles 3,3,3,2 then 0x28, 0x0C, 0x04, 0x01
    function automatic logic [NIB_W-1:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [NIB_W-1:0] nib;
        case (step)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hC;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h4;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Power-up wait first, clear wait last, low nibbles of commands short
    function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
        logic [WAIT_W-1:0] w;
        case (step)
            4'd0:    w = WAIT_POWER;
            4'd1:    w = WAIT_SHORT;
            4'd2:    w = WAIT_SHORT;
            4'd3:    w = WAIT_SHORT;
            4'd4:    w = WAIT_BASE;
            4'd5:    w = WAIT_SHORT;
            4'd6:    w = WAIT_BASE;
            4'd7:    w = WAIT_SHORT;
            4'd8:    w = WAIT_BASE;
            4'd9:    w = WAIT_SHORT;
            4'd10:   w = WAIT_BASE;
            4'd11:   w = WAIT_CLEAR;
            default: w = WAIT_BASE;
        endcase
        return w;
    endfunction

endpackage

/* src/char_lcd_nibble_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer - character LCD request to 4-bit nibble transfers
// The accepting edge loads the request registers and the sequencer state; each transfer
// is then registered in the output registers. Throughput: one transfer per cycle; init
// has 12 transfers, other requests 2, set by the step counter of the sequencer. A start
// is taken only in the idle state, after the last transfer of the previous transaction.
// Reset: synchronous, active low; sequencer idle and strobe low.
// Every transfer is shown for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [clnw_pkg::OP_W-1:0]          i_operation,
    input  logic [clnw_pkg::BYTE_W-1:0]        i_value,
    input  logic [clnw_pkg::COL_W-1:0]         i_column,
    input  logic [clnw_pkg::ROW_W-1:0]         i_row,
    output logic                               o_strobe,
    output logic                               o_rs,
    output logic [clnw_pkg::NIB_W-1:0]         o_nibble,
    output logic [clnw_pkg::WAIT_W-1:0]        o_wait_us,
    output logic                               o_last
);

    clnw_pkg::t_dp_cmd      dp_cmd;
    clnw_pkg::t_dp_status   dp_status;

    // Sequencer
    clnw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    // Request datapath and transfer registers
    clnw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_column    (i_column),
        .i_row       (i_row),
        .o_status    (dp_status),
        .o_strobe    (o_strobe),
        .o_rs        (o_rs),
        .o_nibble    (o_nibble),
        .o_wait_us   (o_wait_us),
        .o_last      (o_last)
    );

endmodule

/* src/clnw_dp.sv */
// ----------------------------------------------------------------------------
// clnw_dp - request datapath
// Latches the request, forms the byte to send (raw, recoded character or
// cursor address) and registers one nibble transfer per emit command.
// ----------------------------------------------------------------------------
module clnw_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  clnw_pkg::t_dp_cmd                  i_cmd,
    input  logic [clnw_pkg::OP_W-1:0]          i_operation,
    input  logic [clnw_pkg::BYTE_W-1:0]        i_value,
    input  logic [clnw_pkg::COL_W-1:0]         i_column,
    input  logic [clnw_pkg::ROW_W-1:0]         i_row,
    output clnw_pkg::t_dp_status               o_status,
    output logic                               o_strobe,
    output logic                               o_rs,
    output logic [clnw_pkg::NIB_W-1:0]         o_nibble,
    output logic [clnw_pkg::WAIT_W-1:0]        o_wait_us,
    output logic                               o_last
);

    clnw_pkg::t_op                     r_op, n_op;
    logic [clnw_pkg::BYTE_W-1:0]       r_byte, n_byte;
    logic                              r_strobe;
    logic                              r_rs;
    logic [clnw_pkg::NIB_W-1:0]        r_nibble, n_nibble;
    logic [clnw_pkg::WAIT_W-1:0]       r_wait, n_wait;
    logic                              r_last, n_last;
    logic [6:0]                        pos_addr;

    // Byte to send for the accepted request
    always_comb begin
        n_op     = clnw_pkg::t_op'(i_operation);
        pos_addr = clnw_pkg::row_base(i_row) + 7'(i_column);
        case (n_op)
            clnw_pkg::OP_CMD: begin
                n_byte = i_value;
            end
            clnw_pkg::OP_CHAR: begin
                // codes 192..255 go through the Cyrillic ROM
                if (i_value[7:6] == 2'b11) begin
                    n_byte = clnw_pkg::CYR_ROM[i_value[5:0]];
                end else begin
                    n_byte = i_value;
                end
            end
            clnw_pkg::OP_CURSOR: begin
                n_byte = clnw_pkg::CMD_SET_DDRAM | {1'b0, pos_addr};
            end
            default: begin
                n_byte = '0;
            end
        endcase
    end

    // Transfer for the current step
    always_comb begin
        if (r_op == clnw_pkg::OP_INIT) begin
            n_nibble = clnw_pkg::init_nibble(i_cmd.step);
            n_wait   = clnw_pkg::init_wait(i_cmd.step);
            n_last   = (i_cmd.step == clnw_pkg::INIT_LAST_STEP);
        end else begin
            n_nibble = i_cmd.step[0] ? r_byte[3:0] : r_byte[7:4];
            n_wait   = clnw_pkg::WAIT_BASE;
            n_last   = (i_cmd.step == clnw_pkg::BYTE_LAST_STEP);
        end
    end

    // Request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= n_op;
            r_byte <= n_byte;
        end
    end

    // Output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            r_last   <= i_cmd.emit & n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rs     <= (r_op == clnw_pkg::OP_CHAR);
            r_nibble <= n_nibble;
            r_wait   <= n_wait;
        end
    end

    assign o_status.init = (r_op == clnw_pkg::OP_INIT);
    assign o_strobe      = r_strobe;
    assign o_rs          = r_rs;
    assign o_nibble      = r_nibble;
    assign o_wait_us     = r_wait;
    assign o_last        = r_last;

    // Checks
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_strobe)
        else $error("last flag without strobe");

    a_byte_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_op != clnw_pkg::OP_INIT) |-> (r_wait == clnw_pkg::WAIT_BASE))
        else $error("non-init transfer with extra wait");

endmodule

/* src/clnw_ctrl.sv */
// ----------------------------------------------------------------------------
// clnw_ctrl - transfer sequencer
// Accepts a request, then steps through its nibble transfers one per cycle:
// twelve for init, two for every other request.
// ----------------------------------------------------------------------------
module clnw_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  clnw_pkg::t_dp_status   i_status,
    output logic                   o_busy,
    output clnw_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [clnw_pkg::STEP_W-1:0]     r_step, n_step;
    logic [clnw_pkg::STEP_W-1:0]     last_step;

    assign last_step = i_status.init ? clnw_pkg::INIT_LAST_STEP : clnw_pkg::BYTE_LAST_STEP;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd.load  = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EMIT;
                    n_step     = '0;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (r_step == last_step) begin
                    n_state = S_IDLE;
                    n_step  = '0;
                end else begin
                    n_step  = r_step + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state == S_EMIT);

    // Checks
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= clnw_pkg::INIT_LAST_STEP)
        else $error("step counter out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && r_step == '0))
        else $error("accepted transaction did not start at step zero");

    a_byte_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && !i_status.init && r_step == clnw_pkg::BYTE_LAST_STEP) |=> !o_busy)
        else $error("two-nibble transaction did not finish");

endmodule

/* verif/tb_char_lcd_nibble_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer - self-checking bench for the LCD nibble writer
// Sends init, raw command, character and cursor requests through the
// start/busy handshake and checks every strobed nibble transfer. Expected
// transfers come from the bench's own model of the 4-bit character LCD protocol.
// A short table of directed requests covers extremes and the Cyrillic recode
// edges. Random requests follow, with random gaps and back-to-back bursts.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer;

    localparam int RANDOM_REQUESTS = 362;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 20;

    // One nibble transfer on the LCD bus
    typedef struct {
        logic                        rs;
        logic [clnw_pkg::NIB_W-1:0]  nibble;
        logic [clnw_pkg::WAIT_W-1:0] wait_us;
        logic                        last;
    } t_transfer;

    // One row of the directed table; a typed row carries the byte on the bus
    typedef struct {
        clnw_pkg::t_op               op;
        logic [clnw_pkg::BYTE_W-1:0] value;
        logic [clnw_pkg::COL_W-1:0]  column;
        logic [clnw_pkg::ROW_W-1:0]  row;
        bit                          typed;
        logic                        bus_rs;
        logic [clnw_pkg::BYTE_W-1:0] bus_byte;
    } t_stim_row;

    // Display character set positions for codes 192..255
    localparam logic [7:0] GLYPH_MAP [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    localparam logic [6:0] DDRAM_ROW_BASE [4] = '{7'h00, 7'h40, 7'h10, 7'h50};

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [clnw_pkg::OP_W-1:0]   i_operation;
    logic [clnw_pkg::BYTE_W-1:0] i_value;
    logic [clnw_pkg::COL_W-1:0]  i_column;
    logic [clnw_pkg::ROW_W-1:0]  i_row;
    logic                        o_strobe;
    logic                        o_rs;
    logic [clnw_pkg::NIB_W-1:0]  o_nibble;
    logic [clnw_pkg::WAIT_W-1:0] o_wait_us;
    logic                        o_last;

    t_transfer pending_transfers [$];
    int        fault_count = 0;
    int        stall_cycles = 0;
    int        burst_left = 0;

    char_lcd_nibble_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_column    (i_column),
        .i_row       (i_row),
        .o_strobe    (o_strobe),
        .o_rs        (o_rs),
        .o_nibble    (o_nibble),
        .o_wait_us   (o_wait_us),
        .o_last      (o_last)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Queue one transfer
    function automatic void push_transfer(logic rs, logic [3:0] nib,
                                          logic [clnw_pkg::WAIT_W-1:0] wait_us,
                                          logic last);
        t_transfer t;
        t.rs      = rs;
        t.nibble  = nib;
        t.wait_us = wait_us;
        t.last    = last;
        pending_transfers.push_back(t);
    endfunction

    // A byte goes out high nibble first; only the low nibble gets extra wait
    function automatic void push_byte(logic rs, logic [7:0] b,
                                      logic [clnw_pkg::WAIT_W-1:0] low_wait, logic last);
        push_transfer(rs, b[7:4], clnw_pkg::WAIT_BASE, 1'b0);
        push_transfer(rs, b[3:0], low_wait, last);
    endfunction

    // Expected transfers for one accepted request
    function automatic void predict_lcd_transfers(clnw_pkg::t_op op, logic [7:0] value,
                                                  logic [3:0] column, logic [1:0] row);
        logic [7:0] glyph;
        logic [6:0] addr;
        case (op)
            clnw_pkg::OP_INIT: begin
                // Wake-up nibbles, then function set, display on, entry mode, clear
                push_transfer(1'b0, 4'h3, clnw_pkg::WAIT_POWER, 1'b0);
                push_transfer(1'b0, 4'h3, clnw_pkg::WAIT_SHORT, 1'b0);
                push_transfer(1'b0, 4'h3, clnw_pkg::WAIT_SHORT, 1'b0);
                push_transfer(1'b0, 4'h2, clnw_pkg::WAIT_SHORT, 1'b0);
                push_byte(1'b0, 8'h28, clnw_pkg::WAIT_SHORT, 1'b0);
                push_byte(1'b0, 8'h0C, clnw_pkg::WAIT_SHORT, 1'b0);
                push_byte(1'b0, 8'h04, clnw_pkg::WAIT_SHORT, 1'b0);
                push_byte(1'b0, 8'h01, clnw_pkg::WAIT_CLEAR, 1'b1);
            end
            clnw_pkg::OP_CMD: push_byte(1'b0, value, clnw_pkg::WAIT_BASE, 1'b1);
            clnw_pkg::OP_CHAR: begin
                glyph = (value > 8'd191) ? GLYPH_MAP[value[5:0]] : value;
                push_byte(1'b1, glyph, clnw_pkg::WAIT_BASE, 1'b1);
            end
            default: begin
                addr = DDRAM_ROW_BASE[row] + {3'b000, column};
                push_byte(1'b0, clnw_pkg::CMD_SET_DDRAM | {1'b0, addr},
                          clnw_pkg::WAIT_BASE, 1'b1);
            end
        endcase
    endfunction

    // Gap before the next request: mostly none or short, a few long, some bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(15, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request at the falling edge and hold it until accepted
    task automatic send_request(t_stim_row req, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= req.op;
        i_value     <= req.value;
        i_column    <= req.column;
        i_row       <= req.row;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (req.typed)
            push_byte(req.bus_rs, req.bus_byte, clnw_pkg::WAIT_BASE, 1'b1);
        else
            predict_lcd_transfers(req.op, req.value, req.column, req.row);
        @(negedge i_clk);
    endtask

    // Hold off until every expected transfer has been seen
    task automatic drain_transfers();
        start <= 1'b0;
        while (pending_transfers.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Transfer checker
    always @(posedge i_clk) begin
        t_transfer exp_t;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_transfers.size() == 0) begin
                $error("unexpected transfer: rs=%0b nibble=%h wait_us=%0d last=%0b",
                       o_rs, o_nibble, o_wait_us, o_last);
                fault_count++;
            end else begin
                exp_t = pending_transfers.pop_front();
                if (o_rs !== exp_t.rs) begin
                    $error("rs: expected %0b, got %0b", exp_t.rs, o_rs);
                    fault_count++;
                end
                if (o_nibble !== exp_t.nibble) begin
                    $error("nibble: expected %h, got %h", exp_t.nibble, o_nibble);
                    fault_count++;
                end
                if (o_wait_us !== exp_t.wait_us) begin
                    $error("wait_us: expected %0d, got %0d", exp_t.wait_us, o_wait_us);
                    fault_count++;
                end
                if (o_last !== exp_t.last) begin
                    $error("last: expected %0b, got %0b", exp_t.last, o_last);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_stim_row directed_rows [18];
        t_stim_row req;
        int        pick;

        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_operation = clnw_pkg::OP_INIT;
        i_value     = '0;
        i_column    = '0;
        i_row       = '0;

        directed_rows = '{
            '{clnw_pkg::OP_INIT,   8'h00, 4'd0,  2'd0, 1'b0, 1'b0, 8'h00},
            '{clnw_pkg::OP_CMD,    8'h00, 4'd0,  2'd0, 1'b1, 1'b0, 8'h00},
            '{clnw_pkg::OP_CMD,    8'hFF, 4'd0,  2'd0, 1'b1, 1'b0, 8'hFF},
            '{clnw_pkg::OP_CMD,    8'hA5, 4'd15, 2'd3, 1'b0, 1'b0, 8'h00},
            '{clnw_pkg::OP_CHAR,   8'h00, 4'd0,  2'd0, 1'b1, 1'b1, 8'h00},
            '{clnw_pkg::OP_CHAR,   8'hBF, 4'd0,  2'd0, 1'b1, 1'b1, 8'hBF},
            '{clnw_pkg::OP_CHAR,   8'hC0, 4'd0,  2'd0, 1'b1, 1'b1, 8'h41},
            '{clnw_pkg::OP_CHAR,   8'hDC, 4'd0,  2'd0, 1'b1, 1'b1, 8'h62},
            '{clnw_pkg::OP_CHAR,   8'hFF, 4'd0,  2'd0, 1'b1, 1'b1, 8'hC7},
            '{clnw_pkg::OP_CHAR,   8'h5A, 4'd9,  2'd2, 1'b0, 1'b0, 8'h00},
            '{clnw_pkg::OP_CURSOR, 8'h00, 4'd0,  2'd0, 1'b1, 1'b0, 8'h80},
            '{clnw_pkg::OP_CURSOR, 8'h00, 4'd15, 2'd1, 1'b1, 1'b0, 8'hCF},
            '{clnw_pkg::OP_CURSOR, 8'h00, 4'd5,  2'd2, 1'b1, 1'b0, 8'h95},
            '{clnw_pkg::OP_CURSOR, 8'h00, 4'd15, 2'd3, 1'b1, 1'b0, 8'hDF},
            '{clnw_pkg::OP_CURSOR, 8'hFF, 4'd10, 2'd0, 1'b0, 1'b0, 8'h00},
            '{clnw_pkg::OP_INIT,   8'hFF, 4'd15, 2'd3, 1'b0, 1'b0, 8'h00},
            '{clnw_pkg::OP_CHAR,   8'hE0, 4'd0,  2'd0, 1'b0, 1'b0, 8'h00},
            '{clnw_pkg::OP_CMD,    8'h01, 4'd0,  2'd0, 1'b0, 1'b0, 8'h00}
        };

        // Reset
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, then let the block go fully idle
        foreach (directed_rows[i]) send_request(directed_rows[i], pick_gap());
        drain_transfers();

        // Random requests; init is rare, characters lean toward the recode range
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       req.op = clnw_pkg::OP_INIT;
            else if (pick < 35) req.op = clnw_pkg::OP_CMD;
            else if (pick < 70) req.op = clnw_pkg::OP_CHAR;
            else                req.op = clnw_pkg::OP_CURSOR;
            if (req.op == clnw_pkg::OP_CHAR && $urandom_range(0, 1) == 1)
                req.value = 8'($urandom_range(192, 255));
            else
                req.value = 8'($urandom_range(0, 255));
            req.column   = 4'($urandom_range(0, 15));
            req.row      = 2'($urandom_range(0, 3));
            req.typed    = 1'b0;
            req.bus_rs   = 1'b0;
            req.bus_byte = '0;
            send_request(req, pick_gap());
            if (n % 97 == 96) drain_transfers();
        end

        // Wind down
        start <= 1'b0;
        while (pending_transfers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_transfers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
